// ===== rtl/sre_pkg.sv =====
// sre_pkg: shared constants, types and command/status structs for the
// scatter-reduce engine. No dependencies.
package sre_pkg;

    // table geometry
    localparam int POINTS   = 1024;
    localparam int COLUMNS  = 4;
    localparam int ENTRIES  = POINTS * COLUMNS;
    localparam int ENTRY_AW = $clog2(ENTRIES);
    localparam int NORM_AW  = $clog2(POINTS);

    // field widths
    localparam int VALUE_W    = 48;
    localparam int COUNT_W    = 16;
    localparam int SAMPLE_W   = 32;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
    localparam int POINT_W    = 10;
    localparam int COLUMN_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_SHIFT = 14;
    localparam int DIV_CNT_W  = $clog2(VALUE_W + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_VALUE = 2'd1;

    // item modes
    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [1:0] {
        KIND_SUM  = 2'd0,
        KIND_MEAN = 2'd1,
        KIND_MAX  = 2'd2,
        KIND_WSUM = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_APPLY,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic apply;
        logic div_start;
        logic take_quot;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_read;
        logic need_div;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/sre_div.sv =====
// sre_div: iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on sre_pkg.
module sre_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sre_pkg::VALUE_W-1:0]  dividend,
    input  logic        [sre_pkg::COUNT_W-1:0]  divisor,
    output logic                                done,
    output logic signed [sre_pkg::VALUE_W-1:0]  quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [sre_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                            neg_reg;
    logic [sre_pkg::VALUE_W-1:0]     quot_reg;
    logic [sre_pkg::COUNT_W-1:0]     rem_reg;
    logic [sre_pkg::COUNT_W-1:0]     dsor_reg;
    logic [sre_pkg::COUNT_W:0]       trial;
    logic                            fits;
    logic [sre_pkg::COUNT_W:0]       rem_sub;

    // one restoring step
    always_comb
    begin
        trial   = {rem_reg, quot_reg[sre_pkg::VALUE_W-1]};
        fits    = trial >= {1'b0, dsor_reg};
        rem_sub = trial - {1'b0, dsor_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= sre_pkg::DIV_CNT_W'(sre_pkg::VALUE_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != sre_pkg::DIV_CNT_W'(1);
            done_reg <= cnt_reg == sre_pkg::DIV_CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // magnitude datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[sre_pkg::VALUE_W-1];
            quot_reg <= dividend[sre_pkg::VALUE_W-1] ? -dividend : dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[sre_pkg::VALUE_W-2:0], fits};
            rem_reg  <= fits ? rem_sub[sre_pkg::COUNT_W-1:0] : trial[sre_pkg::COUNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quot_reg) : $signed(quot_reg);

endmodule

// ===== rtl/sre_datapath.sv =====
// sre_datapath: config registers, value/count/norm memories, multiplier,
// reduce arithmetic, divider and output register. Depends on sre_pkg, sre_div.
module sre_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sre_pkg::cmd_t                         cmd,
    output sre_pkg::stat_t                        stat,
    input  logic                                  cfg_we,
    input  logic        [sre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [sre_pkg::VALUE_W-1:0]    cfg_data,
    input  logic                                  mode,
    input  logic        [sre_pkg::POINT_W-1:0]    point,
    input  logic        [sre_pkg::COLUMN_W-1:0]   column,
    input  logic signed [sre_pkg::SAMPLE_W-1:0]   sample,
    input  logic signed [sre_pkg::WEIGHT_W-1:0]   weight,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [sre_pkg::VALUE_W-1:0]    result_value,
    output logic signed [sre_pkg::VALUE_W-1:0]    norm_sum,
    output logic        [sre_pkg::COUNT_W-1:0]    hit_count
);

    localparam logic signed [sre_pkg::VALUE_W-1:0] VMAX = {1'b0, {(sre_pkg::VALUE_W-1){1'b1}}};
    localparam logic signed [sre_pkg::VALUE_W-1:0] VMIN = {1'b1, {(sre_pkg::VALUE_W-1){1'b0}}};

    // configuration
    sre_pkg::kind_t                        kind_reg;
    logic signed [sre_pkg::VALUE_W-1:0]    clear_value_reg;

    // captured item
    logic                                  mode_reg;
    logic        [sre_pkg::COLUMN_W-1:0]   column_reg;
    logic signed [sre_pkg::SAMPLE_W-1:0]   sample_reg;
    logic signed [sre_pkg::WEIGHT_W-1:0]   weight_reg;
    logic                                  ok_reg;
    logic        [sre_pkg::ENTRY_AW-1:0]   idx_reg;
    logic        [sre_pkg::NORM_AW-1:0]    pidx_reg;
    logic                                  ok_next;
    logic        [sre_pkg::ENTRY_AW-1:0]   idx_next;

    // memories and read data
    logic signed [sre_pkg::VALUE_W-1:0]    value_mem [sre_pkg::ENTRIES];
    logic        [sre_pkg::COUNT_W-1:0]    count_mem [sre_pkg::ENTRIES];
    logic signed [sre_pkg::VALUE_W-1:0]    norm_mem  [sre_pkg::POINTS];
    logic signed [sre_pkg::VALUE_W-1:0]    value_rd_reg;
    logic        [sre_pkg::COUNT_W-1:0]    count_rd_reg;
    logic signed [sre_pkg::VALUE_W-1:0]    norm_rd_reg;

    // clearing sweep
    logic        [sre_pkg::ENTRY_AW-1:0]   clr_cnt_reg;

    // arithmetic
    logic signed [sre_pkg::PROD_W-1:0]     prod_reg;
    logic signed [sre_pkg::VALUE_W:0]      addend;
    logic signed [sre_pkg::VALUE_W:0]      sum_wide;
    logic signed [sre_pkg::VALUE_W-1:0]    sum_sat;
    logic signed [sre_pkg::VALUE_W:0]      norm_wide;
    logic signed [sre_pkg::VALUE_W-1:0]    norm_sat;
    logic signed [sre_pkg::VALUE_W-1:0]    sample_ext;
    logic signed [sre_pkg::VALUE_W-1:0]    value_new;
    logic        [sre_pkg::COUNT_W-1:0]    count_new;
    logic                                  last_col;

    // memory write port
    logic                                  vc_we;
    logic        [sre_pkg::ENTRY_AW-1:0]   vc_addr;
    logic signed [sre_pkg::VALUE_W-1:0]    v_wdata;
    logic        [sre_pkg::COUNT_W-1:0]    c_wdata;
    logic                                  n_we;
    logic        [sre_pkg::NORM_AW-1:0]    n_addr;
    logic signed [sre_pkg::VALUE_W-1:0]    n_wdata;

    // result staging and output
    logic signed [sre_pkg::VALUE_W-1:0]    res_value_reg;
    logic signed [sre_pkg::VALUE_W-1:0]    res_norm_reg;
    logic        [sre_pkg::COUNT_W-1:0]    res_count_reg;
    logic                                  out_valid_reg;
    logic signed [sre_pkg::VALUE_W-1:0]    out_value_reg;
    logic signed [sre_pkg::VALUE_W-1:0]    out_norm_reg;
    logic        [sre_pkg::COUNT_W-1:0]    out_count_reg;
    logic                                  div_done;
    logic signed [sre_pkg::VALUE_W-1:0]    div_quot;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= sre_pkg::KIND_SUM;
            clear_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sre_pkg::CFG_REDUCE_KIND: kind_reg <= sre_pkg::kind_t'(cfg_data[1:0]);
                sre_pkg::CFG_CLEAR_VALUE: clear_value_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // index of the addressed entry
    always_comb
    begin
        ok_next  = (32'(point) < sre_pkg::POINTS) && (32'(column) < sre_pkg::COLUMNS);
        idx_next = sre_pkg::ENTRY_AW'(32'(point) * sre_pkg::COLUMNS + 32'(column));
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            column_reg <= column;
            sample_reg <= sample;
            weight_reg <= weight;
            ok_reg     <= ok_next;
            idx_reg    <= idx_next;
            pidx_reg   <= sre_pkg::NORM_AW'(32'(point));
        end
    end

    // weighted product, registered from the captured sample and weight
    always_ff @(posedge clk)
    begin
        prod_reg <= sample_reg * weight_reg;
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear_wr)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // reduce arithmetic
    always_comb
    begin
        sample_ext = sre_pkg::VALUE_W'(sample_reg);
        if (kind_reg == sre_pkg::KIND_WSUM)
            addend = (sre_pkg::VALUE_W+1)'(prod_reg >>> sre_pkg::FRAC_SHIFT);
        else
            addend = (sre_pkg::VALUE_W+1)'(sample_reg);
        sum_wide = {value_rd_reg[sre_pkg::VALUE_W-1], value_rd_reg} + addend;
        if (sum_wide[sre_pkg::VALUE_W] != sum_wide[sre_pkg::VALUE_W-1])
            sum_sat = sum_wide[sre_pkg::VALUE_W] ? VMIN : VMAX;
        else
            sum_sat = sum_wide[sre_pkg::VALUE_W-1:0];
        norm_wide = {norm_rd_reg[sre_pkg::VALUE_W-1], norm_rd_reg}
                  + (sre_pkg::VALUE_W+1)'(weight_reg);
        if (norm_wide[sre_pkg::VALUE_W] != norm_wide[sre_pkg::VALUE_W-1])
            norm_sat = norm_wide[sre_pkg::VALUE_W] ? VMIN : VMAX;
        else
            norm_sat = norm_wide[sre_pkg::VALUE_W-1:0];
        if (kind_reg == sre_pkg::KIND_MAX)
            value_new = (sample_ext > value_rd_reg) ? sample_ext : value_rd_reg;
        else
            value_new = sum_sat;
        count_new = (count_rd_reg == '1) ? count_rd_reg : count_rd_reg + 1'b1;
        last_col  = 32'(column_reg) == sre_pkg::COLUMNS - 1;
    end

    // memory write selection
    always_comb
    begin
        vc_we   = 1'b0;
        vc_addr = idx_reg;
        v_wdata = value_new;
        c_wdata = count_new;
        n_we    = 1'b0;
        n_addr  = pidx_reg;
        n_wdata = norm_sat;
        if (cmd.clear_wr)
        begin
            vc_we   = 1'b1;
            vc_addr = clr_cnt_reg;
            v_wdata = '0;
            c_wdata = '0;
            n_we    = 32'(clr_cnt_reg) < sre_pkg::POINTS;
            n_addr  = sre_pkg::NORM_AW'(clr_cnt_reg);
            n_wdata = '0;
        end
        else if (cmd.apply && ok_reg)
        begin
            vc_we = 1'b1;
            if (mode_reg == sre_pkg::MODE_READ)
            begin
                v_wdata = clear_value_reg;
                c_wdata = '0;
                n_we    = last_col;
                n_wdata = '0;
            end
            else
            begin
                n_we = (kind_reg == sre_pkg::KIND_WSUM) && (column_reg == '0);
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (vc_we)
        begin
            value_mem[vc_addr] <= v_wdata;
            count_mem[vc_addr] <= c_wdata;
        end
        if (n_we)
            norm_mem[n_addr] <= n_wdata;
        value_rd_reg <= value_mem[idx_reg];
        count_rd_reg <= count_mem[idx_reg];
        norm_rd_reg  <= norm_mem[pidx_reg];
    end

    // mean divider
    sre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (value_rd_reg),
        .divisor  (count_rd_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            res_value_reg <= ok_reg ? value_rd_reg : '0;
            res_norm_reg  <= ok_reg ? norm_rd_reg : '0;
            res_count_reg <= ok_reg ? count_rd_reg : '0;
        end
        else if (cmd.take_quot)
        begin
            res_value_reg <= div_quot;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg <= res_value_reg;
            out_norm_reg  <= res_norm_reg;
            out_count_reg <= res_count_reg;
        end
    end

    // status back to the controller
    always_comb
    begin
        stat.clear_done = clr_cnt_reg == sre_pkg::ENTRY_AW'(sre_pkg::ENTRIES - 1);
        stat.is_read    = mode_reg == sre_pkg::MODE_READ;
        stat.need_div   = ok_reg && (kind_reg == sre_pkg::KIND_MEAN) && (count_rd_reg != '0);
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign norm_sum     = out_norm_reg;
    assign hit_count    = out_count_reg;

endmodule

// ===== rtl/sre_ctrl.sv =====
// sre_ctrl: sequencing state machine for the scatter-reduce engine.
// Depends on sre_pkg.
module sre_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sre_pkg::stat_t  stat,
    output sre_pkg::cmd_t   cmd
);

    sre_pkg::state_t state_reg;
    sre_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sre_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = state_reg != sre_pkg::ST_IDLE;
        unique case (state_reg)
            sre_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_done)
                    state_next = sre_pkg::ST_IDLE;
            end
            sre_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sre_pkg::ST_FETCH;
                end
            end
            sre_pkg::ST_FETCH:
            begin
                state_next = sre_pkg::ST_APPLY;
            end
            sre_pkg::ST_APPLY:
            begin
                cmd.apply = 1'b1;
                if (!stat.is_read)
                    state_next = sre_pkg::ST_IDLE;
                else if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = sre_pkg::ST_DIV;
                end
                else
                    state_next = sre_pkg::ST_OUT;
            end
            sre_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.take_quot = 1'b1;
                    state_next    = sre_pkg::ST_OUT;
                end
            end
            sre_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = sre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sre_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/scatter_reduce_engine.sv =====
// scatter_reduce_engine: top level of the scatter-reduce table.
// Depends on sre_pkg, sre_ctrl, sre_datapath.
//
//  channel  | beat fields                               | handshake
//  ---------+-------------------------------------------+------------------
//  in       | mode, point, column, sample, weight       | in_valid/in_stall
//  out      | result_value, norm_sum, hit_count         | out_valid/out_stall
//  cfg      | cfg_index, cfg_data                       | cfg_we
//
// accumulate beat: capture, memory read, read-modify-write
// read beat: capture, memory read, apply, bit-serial divide (mean, nonzero count), output
// after reset a sweep over the 4096 entries zeroes the memories; in_stall stays high meanwhile
// a result waits in the output register; a stalled output holds the next read in its last step
module scatter_reduce_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [sre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [sre_pkg::VALUE_W-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  mode,
    input  logic        [sre_pkg::POINT_W-1:0]    point,
    input  logic        [sre_pkg::COLUMN_W-1:0]   column,
    input  logic signed [sre_pkg::SAMPLE_W-1:0]   sample,
    input  logic signed [sre_pkg::WEIGHT_W-1:0]   weight,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [sre_pkg::VALUE_W-1:0]    result_value,
    output logic signed [sre_pkg::VALUE_W-1:0]    norm_sum,
    output logic        [sre_pkg::COUNT_W-1:0]    hit_count
);

    sre_pkg::cmd_t  cmd;
    sre_pkg::stat_t stat;

    // controller
    sre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    sre_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .point        (point),
        .column       (column),
        .sample       (sample),
        .weight       (weight),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .norm_sum     (norm_sum),
        .hit_count    (hit_count)
    );

endmodule

// ===== rtl/sre_checker.sv =====
// sre_checker: port-level assertions for scatter_reduce_engine, bound to the top.
// Depends on sre_pkg.
module sre_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [sre_pkg::VALUE_W-1:0]       result_value
);

    // a waiting result beat is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a waiting result beat holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_value))
        else $error("result value changed while stalled");

    // one item at a time: busy right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while previous item in flight");

    // a new result only comes out of a busy block
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in flight");

endmodule

bind scatter_reduce_engine sre_checker u_sre_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value)
);

// ===== tb/tb.sv =====
// tb: self-checking testbench for scatter_reduce_engine
// depends on sre_pkg and the scatter_reduce_engine rtl; runs directed then random beats
`timescale 1ns / 1ps

module tb;

    localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam logic [sre_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [sre_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic                                mode;
        logic [sre_pkg::POINT_W-1:0]         point;
        logic [sre_pkg::COLUMN_W-1:0]        column;
        logic signed [sre_pkg::SAMPLE_W-1:0] sample;
        logic signed [sre_pkg::WEIGHT_W-1:0] weight;
    } beat_t;

    typedef struct {
        logic signed [sre_pkg::VALUE_W-1:0] value;
        logic signed [sre_pkg::VALUE_W-1:0] norm;
        logic [sre_pkg::COUNT_W-1:0]        count;
    } readout_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sre_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sre_pkg::VALUE_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic mode;
    logic [sre_pkg::POINT_W-1:0] point;
    logic [sre_pkg::COLUMN_W-1:0] column;
    logic signed [sre_pkg::SAMPLE_W-1:0] sample;
    logic signed [sre_pkg::WEIGHT_W-1:0] weight;
    logic out_valid;
    logic out_stall;
    logic signed [sre_pkg::VALUE_W-1:0] result_value;
    logic signed [sre_pkg::VALUE_W-1:0] norm_sum;
    logic [sre_pkg::COUNT_W-1:0] hit_count;

    // shadow of the table and registers
    longint          val_tbl [sre_pkg::ENTRIES];
    int unsigned     cnt_tbl [sre_pkg::ENTRIES];
    longint          norm_tbl [sre_pkg::POINTS];
    sre_pkg::kind_t  kind_reg;
    longint          clear_reg;

    beat_t    pending_q [$];
    readout_t readout_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int beats_in;
    int beats_out;
    int idle_cycles;

    scatter_reduce_engine dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .point(point), .column(column), .sample(sample), .weight(weight),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_value(result_value), .norm_sum(norm_sum), .hit_count(hit_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat48(longint v);
        if (v > ACC_MAX)
            return ACC_MAX;
        if (v < ACC_MIN)
            return ACC_MIN;
        return v;
    endfunction

    // apply one accepted beat to the shadow table, queue a readout for reads
    function automatic void reduce_beat(beat_t b);
        int idx;
        longint s;
        longint w;
        longint v;
        readout_t r;
        idx = int'(b.point) * sre_pkg::COLUMNS + int'(b.column);
        s = longint'(b.sample);
        w = longint'(b.weight);
        if (b.mode == sre_pkg::MODE_ACCUM)
        begin
            case (kind_reg) inside
                sre_pkg::KIND_SUM, sre_pkg::KIND_MEAN:
                    val_tbl[idx] = sat48(val_tbl[idx] + s);
                sre_pkg::KIND_MAX:
                begin
                    if (s > val_tbl[idx])
                        val_tbl[idx] = s;
                end
                default:
                begin
                    // arithmetic shift floors the Q34.14 product
                    val_tbl[idx] = sat48(val_tbl[idx] + ((w * s) >>> sre_pkg::FRAC_SHIFT));
                    if (b.column == 0)
                        norm_tbl[b.point] = sat48(norm_tbl[b.point] + w);
                end
            endcase
            if (cnt_tbl[idx] != 65535)
                cnt_tbl[idx]++;
        end
        else
        begin
            v = val_tbl[idx];
            if (kind_reg == sre_pkg::KIND_MEAN && cnt_tbl[idx] != 0)
                v = v / longint'(cnt_tbl[idx]);
            r.value = v[sre_pkg::VALUE_W-1:0];
            r.norm = norm_tbl[b.point][sre_pkg::VALUE_W-1:0];
            r.count = cnt_tbl[idx][sre_pkg::COUNT_W-1:0];
            readout_q.push_back(r);
            val_tbl[idx] = clear_reg;
            cnt_tbl[idx] = 0;
            if (b.column == sre_pkg::COLUMNS - 1)
                norm_tbl[b.point] = 0;
        end
    endfunction

    function automatic void add_beat(logic m, int p, int c, longint s, longint w);
        beat_t b;
        b.mode = m;
        b.point = p[sre_pkg::POINT_W-1:0];
        b.column = c[sre_pkg::COLUMN_W-1:0];
        b.sample = s[sre_pkg::SAMPLE_W-1:0];
        b.weight = w[sre_pkg::WEIGHT_W-1:0];
        pending_q.push_back(b);
    endfunction

    function automatic void add_random_beat();
        beat_t b;
        b.mode = ($urandom_range(99) < 30) ? sre_pkg::MODE_READ : sre_pkg::MODE_ACCUM;
        // mostly a few hot points so reads find accumulated entries
        b.point = ($urandom_range(99) < 80)
                ? sre_pkg::POINT_W'($urandom_range(7))
                : sre_pkg::POINT_W'($urandom_range(sre_pkg::POINTS - 1));
        b.column = sre_pkg::COLUMN_W'($urandom_range(sre_pkg::COLUMNS - 1));
        case ($urandom_range(9))
            0: b.sample = 32'sh7FFF_FFFF;
            1: b.sample = 32'sh8000_0000;
            2: b.sample = sre_pkg::SAMPLE_W'($urandom_range(255));
            default: b.sample = $urandom;
        endcase
        case ($urandom_range(7))
            0: b.weight = 16'sh7FFF;
            1: b.weight = 16'sh8000;
            default: b.weight = sre_pkg::WEIGHT_W'($urandom);
        endcase
        pending_q.push_back(b);
    endfunction

    // wait for the table to drain, then give the last accumulate time to land
    task automatic drain();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || readout_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [sre_pkg::CFG_IDX_W-1:0] idx, longint data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[sre_pkg::VALUE_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sre_pkg::CFG_REDUCE_KIND)
            kind_reg = sre_pkg::kind_t'(data[1:0]);
        else if (idx == sre_pkg::CFG_CLEAR_VALUE)
            clear_reg = longint'($signed(data[sre_pkg::VALUE_W-1:0]));
    endtask

    // input driver: hold a stalled beat, otherwise offer the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                reduce_beat(pending_q.pop_front());
                beats_in++;
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    mode <= pending_q[0].mode;
                    point <= pending_q[0].point;
                    column <= pending_q[0].column;
                    sample <= pending_q[0].sample;
                    weight <= pending_q[0].weight;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (readout_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat value=%0d norm=%0d count=%0d",
                             $time, result_value, norm_sum, hit_count);
                    fail_count++;
                end
                else
                begin
                    readout_t r;
                    r = readout_q.pop_front();
                    if (result_value !== r.value)
                    begin
                        $display("%0t: result_value expected %0d actual %0d",
                                 $time, r.value, result_value);
                        fail_count++;
                    end
                    if (norm_sum !== r.norm)
                    begin
                        $display("%0t: norm_sum expected %0d actual %0d",
                                 $time, r.norm, norm_sum);
                        fail_count++;
                    end
                    if (hit_count !== r.count)
                    begin
                        $display("%0t: hit_count expected %0d actual %0d",
                                 $time, r.count, hit_count);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d readouts pending",
                         $time, readout_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        longint clear_pick;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mode = 1'b0;
        point = '0;
        column = '0;
        sample = '0;
        weight = '0;
        send_idle_pct = 27;
        recv_idle_pct = 58;
        fail_count = 0;
        beats_in = 0;
        beats_out = 0;
        idle_cycles = 0;
        kind_reg = sre_pkg::KIND_SUM;
        clear_reg = 0;
        foreach (val_tbl[i])
        begin
            val_tbl[i] = 0;
            cnt_tbl[i] = 0;
        end
        foreach (norm_tbl[i])
            norm_tbl[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // spare indexes must not disturb the registers
        write_reg(CFG_SPARE_A, -1);
        write_reg(CFG_SPARE_B, -1);
        write_reg(sre_pkg::CFG_REDUCE_KIND, sre_pkg::KIND_SUM);
        write_reg(sre_pkg::CFG_CLEAR_VALUE, 0);

        // plain sums with sample extremes
        add_beat(sre_pkg::MODE_ACCUM, 5, 0, 32'sh7FFF_FFFF, 0);
        add_beat(sre_pkg::MODE_ACCUM, 5, 0, 32'sh7FFF_FFFF, 0);
        add_beat(sre_pkg::MODE_READ, 5, 0, 0, 0);
        add_beat(sre_pkg::MODE_ACCUM, 1023, 3, -64'sh8000_0000, 0);
        add_beat(sre_pkg::MODE_READ, 1023, 3, 0, 0);
        drain();

        // saturation at both ends through the clear value
        write_reg(sre_pkg::CFG_CLEAR_VALUE, ACC_MAX - 1);
        add_beat(sre_pkg::MODE_READ, 6, 0, 0, 0);
        drain();
        write_reg(sre_pkg::CFG_CLEAR_VALUE, ACC_MIN);
        add_beat(sre_pkg::MODE_READ, 6, 1, 0, 0);
        add_beat(sre_pkg::MODE_ACCUM, 6, 0, 100, 0);
        add_beat(sre_pkg::MODE_ACCUM, 6, 1, -64'sh8000_0000, 0);
        add_beat(sre_pkg::MODE_READ, 6, 0, 0, 0);
        add_beat(sre_pkg::MODE_READ, 6, 1, 0, 0);
        drain();

        // mean truncates toward zero, zero count leaves value alone
        write_reg(sre_pkg::CFG_REDUCE_KIND, sre_pkg::KIND_MEAN);
        write_reg(sre_pkg::CFG_CLEAR_VALUE, 0);
        add_beat(sre_pkg::MODE_ACCUM, 7, 0, -7, 0);
        add_beat(sre_pkg::MODE_ACCUM, 7, 0, 0, 0);
        add_beat(sre_pkg::MODE_READ, 7, 0, 0, 0);
        add_beat(sre_pkg::MODE_READ, 7, 0, 0, 0);
        drain();

        // max replaces only on strictly larger
        write_reg(sre_pkg::CFG_REDUCE_KIND, sre_pkg::KIND_MAX);
        add_beat(sre_pkg::MODE_ACCUM, 8, 2, -5, 0);
        add_beat(sre_pkg::MODE_ACCUM, 8, 2, 3, 0);
        add_beat(sre_pkg::MODE_ACCUM, 8, 2, 3, 0);
        add_beat(sre_pkg::MODE_READ, 8, 2, 0, 0);
        drain();

        // weighted sum: floor shift, norm on column zero, norm cleared by last column
        write_reg(sre_pkg::CFG_REDUCE_KIND, sre_pkg::KIND_WSUM);
        add_beat(sre_pkg::MODE_ACCUM, 9, 0, -3, 1);
        add_beat(sre_pkg::MODE_ACCUM, 9, 0, 32'sh7FFF_FFFF, -32768);
        add_beat(sre_pkg::MODE_ACCUM, 9, 3, -64'sh8000_0000, -32768);
        add_beat(sre_pkg::MODE_READ, 9, 0, 0, 0);
        add_beat(sre_pkg::MODE_READ, 9, 3, 0, 0);
        add_beat(sre_pkg::MODE_READ, 9, 0, 0, 0);
        drain();

        // hit count over a run of accumulates into one entry
        write_reg(sre_pkg::CFG_REDUCE_KIND, sre_pkg::KIND_SUM);
        for (int i = 0; i < 40; i++)
            add_beat(sre_pkg::MODE_ACCUM, 10, 2, 1, 0);
        add_beat(sre_pkg::MODE_READ, 10, 2, 0, 0);
        drain();

        // random phases over every kind and a spread of clear values
        for (int ph = 0; ph < 12; ph++)
        begin
            send_idle_pct = (ph < 4) ? 27 : (ph < 8) ? 58 : 0;
            recv_idle_pct = (ph < 4) ? 58 : (ph < 8) ? 27 : 0;
            case (ph % 3)
                0: clear_pick = (ph % 2) ? ACC_MAX : ACC_MIN;
                1: clear_pick = 0;
                default: clear_pick = {$urandom, $urandom};
            endcase
            write_reg(sre_pkg::CFG_REDUCE_KIND, ph % 4);
            write_reg(sre_pkg::CFG_CLEAR_VALUE, clear_pick);
            for (int i = 0; i < 170; i++)
                add_random_beat();
            drain();
        end

        repeat (100) @(posedge clk);
        $display("covered %0d input beats and %0d readouts across all four reduce kinds",
                 beats_in, beats_out);
        $display("including saturation, hit counting, mean division and norm clearing");
        if (fail_count == 0 && readout_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sre_pkg.sv
rtl/sre_div.sv
rtl/sre_datapath.sv
rtl/sre_ctrl.sv
rtl/scatter_reduce_engine.sv
rtl/sre_checker.sv
tb/tb.sv
